// ===== sv/vrf_pkg.sv =====
// shared types and constants for the video register file with raster interrupt
`timescale 1ns / 1ps

package vrf_pkg;

  localparam int ADDR_BITS = 7;
  localparam int DATA_BITS = 8;
  localparam int LINE_BITS = 9;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [ADDR_BITS-1:0] ADR_CMP_HI     = 7'h11;
  localparam logic [ADDR_BITS-1:0] ADR_CMP_LO     = 7'h12;
  localparam logic [ADDR_BITS-1:0] ADR_CTRL2      = 7'h16;
  localparam logic [ADDR_BITS-1:0] ADR_MEMPTR     = 7'h18;
  localparam logic [ADDR_BITS-1:0] ADR_IRQ_STATUS = 7'h19;
  localparam logic [ADDR_BITS-1:0] ADR_IRQ_ENABLE = 7'h1A;
  localparam logic [ADDR_BITS-1:0] ADR_EXT_LO     = 7'h20;
  localparam logic [ADDR_BITS-1:0] ADR_KEY        = 7'h2F;
  localparam logic [ADDR_BITS-1:0] ADR_MAP        = 7'h30;
  localparam logic [ADDR_BITS-1:0] ADR_CLOCK      = 7'h31;

  localparam logic [DATA_BITS-1:0] KEY_FIRST   = 8'hA5;
  localparam logic [DATA_BITS-1:0] KEY_SECOND  = 8'h96;
  localparam logic [DATA_BITS-1:0] RD_UNMAPPED = 8'hFF;
  localparam logic [DATA_BITS-1:0] OR_CTRL2    = 8'hC0;
  localparam logic [DATA_BITS-1:0] OR_MEMPTR   = 8'h01;
  localparam logic [DATA_BITS-1:0] OR_STATUS   = 8'h70;
  localparam logic [DATA_BITS-1:0] OR_NIBBLE   = 8'hF0;
  localparam logic [DATA_BITS-1:0] MAP_MASK    = 8'hF8;
  localparam logic [DATA_BITS-1:0] IRQ_ANY     = 8'h80;
  localparam logic [LINE_BITS-1:0] LINE_WRAP   = 9'd511;
  localparam int                   CLOCK_BIT   = 6;

  typedef struct packed {
    logic [1:0]           command;
    logic [ADDR_BITS-1:0] reg_address;
    logic [DATA_BITS-1:0] write_data;
    logic [LINE_BITS-1:0] current_line;
  } item_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] read_data;
    logic                 irq_active;
    logic                 memory_map_changed;
    logic                 slow_clock_select;
    logic                 extended_mode;
  } result_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
    logic [DATA_BITS-1:0] data;
  } bank_wr_t;

endpackage

// ===== sv/vrf_item_if.sv =====
// valid/ready channel carrying register file command beats
`timescale 1ns / 1ps

interface vrf_item_if;
  logic          valid;
  logic          ready;
  vrf_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/vrf_result_if.sv =====
// valid/ready channel carrying register file result beats
`timescale 1ns / 1ps

interface vrf_result_if;
  logic            valid;
  logic            ready;
  vrf_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/video_chip_register_file_raster_irq.sv =====
// top level of the video register file with raster compare interrupt
//
//   channel    dir  beats                  payload
//   request    in   write / read / tick    command, reg_address, write_data, current_line
//   response   out  one per request beat   read_data, irq_active, memory_map_changed,
//                                          slow_clock_select, extended_mode
//
// one beat per clock sustained while the response is taken; a result passes the input
// register (with the bank read), then the result register
// reset clears the mode, compare, status and the bank valid bits at once
// a stalled response holds the item in the input register and request.ready
// drops only while both stages are full and the response is not taken
`timescale 1ns / 1ps

module video_chip_register_file_raster_irq #(
  parameter int REG_COUNT = 128
) (
  input  logic              clk,
  input  logic              rst,
  vrf_item_if.sink          request,
  vrf_result_if.source      response
);

  logic                          s1_valid;
  vrf_pkg::item_t                s1_item;
  logic                          out_valid;
  vrf_pkg::result_t              out_item;
  logic                          advance;
  logic                          accept;
  logic [vrf_pkg::DATA_BITS-1:0] rd_full;
  logic [vrf_pkg::DATA_BITS-1:0] rd_low;
  vrf_pkg::bank_wr_t             wr;
  vrf_pkg::result_t              res;

  assign advance         = s1_valid && (!out_valid || response.ready);
  assign request.ready   = !s1_valid || advance;
  assign accept          = request.valid && request.ready;
  assign response.valid  = out_valid;
  assign response.data   = out_item;

  vrf_bank #(
    .REG_COUNT (REG_COUNT)
  ) u_bank (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_en   (accept),
    .rd_addr (request.data.reg_address),
    .rd_full (rd_full),
    .rd_low  (rd_low)
  );

  vrf_exec #(
    .REG_COUNT (REG_COUNT)
  ) u_exec (
    .clk     (clk),
    .rst     (rst),
    .commit  (advance),
    .item    (s1_item),
    .rd_full (rd_full),
    .rd_low  (rd_low),
    .wr      (wr),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= request.data;
    end
    if (advance) begin
      out_item <= res;
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> response.valid)
    else $error("committed beat produced no result");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |-> !request.ready)
    else $error("request taken while input stage is held");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (advance && (s1_item.command != vrf_pkg::CMD_READ)) |=> (response.data.read_data == '0))
    else $error("non-read beat returned read data");

endmodule

// ===== sv/vrf_bank.sv =====
// register bank memory with per-entry valid bits, two read ports and write bypass
`timescale 1ns / 1ps

module vrf_bank #(
  parameter int REG_COUNT = 128
) (
  input  logic                               clk,
  input  logic                               rst,
  input  vrf_pkg::bank_wr_t                  wr,
  input  logic                               rd_en,
  input  logic [vrf_pkg::ADDR_BITS-1:0]      rd_addr,
  output logic [vrf_pkg::DATA_BITS-1:0]      rd_full,
  output logic [vrf_pkg::DATA_BITS-1:0]      rd_low
);

  localparam int IDX_W = $clog2(REG_COUNT);

  logic [vrf_pkg::DATA_BITS-1:0] mem [REG_COUNT];
  logic [REG_COUNT-1:0]          vld;

  logic [vrf_pkg::ADDR_BITS-1:0] addr_full;
  logic [vrf_pkg::ADDR_BITS-1:0] addr_low;
  logic [IDX_W-1:0]              idx_full;
  logic [IDX_W-1:0]              idx_low;
  logic [IDX_W-1:0]              idx_wr;

  logic [vrf_pkg::DATA_BITS-1:0] q_full;
  logic [vrf_pkg::DATA_BITS-1:0] q_low;
  logic                          v_full;
  logic                          v_low;
  logic                          hit_full;
  logic                          hit_low;
  logic [vrf_pkg::DATA_BITS-1:0] byp;

  assign addr_full = rd_addr;
  assign addr_low  = {1'b0, rd_addr[vrf_pkg::ADDR_BITS-2:0]};
  assign idx_full  = addr_full[IDX_W-1:0];
  assign idx_low   = addr_low[IDX_W-1:0];
  assign idx_wr    = wr.addr[IDX_W-1:0];

  // payload storage and registered read ports
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[idx_wr] <= wr.data;
    end
    if (rd_en) begin
      q_full   <= mem[idx_full];
      q_low    <= mem[idx_low];
      hit_full <= wr.en && (wr.addr == addr_full);
      hit_low  <= wr.en && (wr.addr == addr_low);
      byp      <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      v_full <= 1'b0;
      v_low  <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[idx_wr] <= 1'b1;
      end
      if (rd_en) begin
        v_full <= vld[idx_full];
        v_low  <= vld[idx_low];
      end
    end
  end

  assign rd_full = hit_full ? byp : (v_full ? q_full : '0);
  assign rd_low  = hit_low  ? byp : (v_low  ? q_low  : '0);

endmodule

// ===== sv/vrf_exec.sv =====
// command decode, raster compare, interrupt state and result formation
`timescale 1ns / 1ps

module vrf_exec #(
  parameter int REG_COUNT = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          commit,
  input  vrf_pkg::item_t                item,
  input  logic [vrf_pkg::DATA_BITS-1:0] rd_full,
  input  logic [vrf_pkg::DATA_BITS-1:0] rd_low,
  output vrf_pkg::bank_wr_t             wr,
  output vrf_pkg::result_t              res
);

  localparam logic [vrf_pkg::ADDR_BITS:0] REG_LIMIT = (vrf_pkg::ADDR_BITS + 1)'(REG_COUNT);

  logic                          unlocked;
  logic [vrf_pkg::LINE_BITS-1:0] cmp;
  logic [vrf_pkg::DATA_BITS-1:0] status;
  logic                          level;
  logic [3:0]                    en;
  logic                          clk_sel;

  logic                          unlocked_next;
  logic [vrf_pkg::LINE_BITS-1:0] cmp_next;
  logic [vrf_pkg::DATA_BITS-1:0] status_next;
  logic                          level_next;
  logic [3:0]                    en_next;
  logic                          clk_sel_next;

  logic [vrf_pkg::ADDR_BITS-1:0] eff_addr;
  logic [vrf_pkg::DATA_BITS-1:0] old;
  logic                          in_range;
  logic                          blocked;
  logic                          match;
  logic                          settle;
  logic [vrf_pkg::DATA_BITS-1:0] stat_pre;
  logic [vrf_pkg::DATA_BITS-1:0] read_val;
  logic                          mm;
  vrf_pkg::bank_wr_t             wr_req;

  assign eff_addr = unlocked ? item.reg_address
                             : {1'b0, item.reg_address[vrf_pkg::ADDR_BITS-2:0]};
  assign old      = unlocked ? rd_full : rd_low;
  assign in_range = {1'b0, eff_addr} < REG_LIMIT;
  assign blocked  = (!unlocked && (eff_addr > vrf_pkg::ADR_KEY)) || !in_range;
  assign match    = (item.current_line == cmp) ||
                    ((cmp == vrf_pkg::LINE_WRAP) && (item.current_line == '0));

  // read decode with live raster position and forced-high unused bits
  always_comb begin
    unique case (eff_addr)
      vrf_pkg::ADR_CMP_HI:     read_val = {item.current_line[8], old[6:0]};
      vrf_pkg::ADR_CMP_LO:     read_val = item.current_line[7:0];
      vrf_pkg::ADR_CTRL2:      read_val = old | vrf_pkg::OR_CTRL2;
      vrf_pkg::ADR_MEMPTR:     read_val = old | vrf_pkg::OR_MEMPTR;
      vrf_pkg::ADR_IRQ_STATUS: read_val = status | vrf_pkg::OR_STATUS;
      vrf_pkg::ADR_IRQ_ENABLE: read_val = old | vrf_pkg::OR_NIBBLE;
      default: begin
        if ((eff_addr >= vrf_pkg::ADR_EXT_LO) && (eff_addr < vrf_pkg::ADR_KEY)) begin
          read_val = old | vrf_pkg::OR_NIBBLE;
        end else begin
          read_val = old;
        end
      end
    endcase
  end

  always_comb begin
    unlocked_next = unlocked;
    cmp_next      = cmp;
    status_next   = status;
    level_next    = level;
    en_next       = en;
    clk_sel_next  = clk_sel;
    settle        = 1'b0;
    stat_pre      = status;
    mm            = 1'b0;
    wr_req        = '0;

    case (item.command)
      vrf_pkg::CMD_WRITE: begin
        // unlock key sequence on the key register
        if (eff_addr == vrf_pkg::ADR_KEY) begin
          if (!unlocked && (item.write_data == vrf_pkg::KEY_SECOND) &&
              (old == vrf_pkg::KEY_FIRST)) begin
            unlocked_next = 1'b1;
          end else if (unlocked) begin
            unlocked_next = 1'b0;
          end
        end
        if (!blocked) begin
          wr_req.en   = 1'b1;
          wr_req.addr = eff_addr;
          wr_req.data = item.write_data;
          unique case (eff_addr)
            vrf_pkg::ADR_CMP_HI: cmp_next = {item.write_data[7], cmp[7:0]};
            vrf_pkg::ADR_CMP_LO: cmp_next = {cmp[8], item.write_data};
            vrf_pkg::ADR_IRQ_STATUS: begin
              // write one to clear
              stat_pre = status & ~item.write_data & {4'b0000, en};
              settle   = 1'b1;
            end
            vrf_pkg::ADR_IRQ_ENABLE: begin
              wr_req.data = {4'b0000, item.write_data[3:0]};
              en_next     = item.write_data[3:0];
            end
            vrf_pkg::ADR_MAP:   mm = |((item.write_data ^ old) & vrf_pkg::MAP_MASK);
            vrf_pkg::ADR_CLOCK: clk_sel_next = item.write_data[vrf_pkg::CLOCK_BIT];
            default: ;
          endcase
        end
      end
      vrf_pkg::CMD_TICK: begin
        stat_pre = {status[7:1], match} & {4'b0000, en};
        settle   = 1'b1;
      end
      default: ;
    endcase

    if (settle) begin
      if (stat_pre != '0) begin
        status_next = stat_pre | vrf_pkg::IRQ_ANY;
        level_next  = 1'b1;
      end else begin
        status_next = '0;
        level_next  = 1'b0;
      end
    end
  end

  always_comb begin
    wr    = wr_req;
    wr.en = wr_req.en && commit;
  end

  always_comb begin
    res.read_data          = '0;
    if (item.command == vrf_pkg::CMD_READ) begin
      res.read_data = blocked ? vrf_pkg::RD_UNMAPPED : read_val;
    end
    res.irq_active         = level_next;
    res.memory_map_changed = mm;
    res.slow_clock_select  = clk_sel_next;
    res.extended_mode      = unlocked_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unlocked <= 1'b0;
      cmp      <= '0;
      status   <= '0;
      level    <= 1'b0;
      en       <= '0;
      clk_sel  <= 1'b0;
    end else if (commit) begin
      unlocked <= unlocked_next;
      cmp      <= cmp_next;
      status   <= status_next;
      level    <= level_next;
      en       <= en_next;
      clk_sel  <= clk_sel_next;
    end
  end

  a_level_tracks_status: assert property (@(posedge clk) disable iff (rst)
    level == (status != '0))
    else $error("irq line disagrees with status");

  a_unlock_by_write: assert property (@(posedge clk) disable iff (rst)
    $rose(unlocked) |-> $past(commit && (item.command == vrf_pkg::CMD_WRITE)))
    else $error("extended mode entered without a write beat");

endmodule

// ===== verif/video_chip_register_file_raster_irq_tb.sv =====
// self-checking testbench for the video register file with raster compare interrupt
`timescale 1ns / 1ps

module video_chip_register_file_raster_irq_tb;

  localparam logic [1:0]                    CMD_NONE       = 2'd3;
  localparam logic [vrf_pkg::ADDR_BITS-1:0] MASK_EXT       = 7'h7F;
  localparam logic [vrf_pkg::ADDR_BITS-1:0] MASK_LOCKED    = 7'h3F;
  localparam logic [vrf_pkg::ADDR_BITS-1:0] ADR_EXT_HI     = 7'h2E;
  localparam logic [vrf_pkg::ADDR_BITS-1:0] ADR_LOCKED_TOP = 7'h3F;
  localparam logic [vrf_pkg::ADDR_BITS-1:0] ADR_UPPER      = 7'h40;
  localparam logic [vrf_pkg::ADDR_BITS-1:0] ADR_TOP        = 7'h7F;
  localparam int                            RANDOM_BEATS   = 1600;
  localparam int                            STALL_LIMIT    = 5000;
  localparam int                            DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic           hold;
    vrf_pkg::item_t beat;
  } queued_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vrf_item_if   request ();
  vrf_result_if response ();

  video_chip_register_file_raster_irq uut (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .response (response)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [vrf_pkg::DATA_BITS-1:0] shadow_bank [0:127];
  logic                          shadow_unlocked;
  logic [vrf_pkg::LINE_BITS-1:0] shadow_compare;
  logic [vrf_pkg::DATA_BITS-1:0] shadow_status;
  logic                          shadow_irq;

  queued_beat_t                  pending_beats [$];
  vrf_pkg::result_t              expected_responses [$];
  vrf_pkg::result_t              want;
  queued_beat_t                  next_beat;
  logic [vrf_pkg::LINE_BITS-1:0] gen_compare;
  int                            beats_taken;
  int                            total_beats;
  int                            failures;
  int                            quiet_cycles;

  function automatic logic [vrf_pkg::DATA_BITS-1:0] rand_data();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [vrf_pkg::LINE_BITS-1:0] rand_line();
    return 9'($urandom_range(511));
  endfunction

  function automatic logic [vrf_pkg::ADDR_BITS-1:0] rand_addr();
    return 7'($urandom_range(127));
  endfunction

  function automatic logic rand_hold();
    return ($urandom_range(149) == 0);
  endfunction

  function automatic void settle_irq_line();
    if (shadow_status != '0) begin
      shadow_status = shadow_status | vrf_pkg::IRQ_ANY;
      shadow_irq    = 1'b1;
    end else begin
      shadow_irq = 1'b0;
    end
  endfunction

  function automatic vrf_pkg::result_t predict_response(vrf_pkg::item_t b);
    vrf_pkg::result_t              r;
    logic [vrf_pkg::ADDR_BITS-1:0] a;
    logic [vrf_pkg::DATA_BITS-1:0] old;
    r = '0;
    a = b.reg_address & (shadow_unlocked ? MASK_EXT : MASK_LOCKED);
    case (b.command)
      vrf_pkg::CMD_WRITE: begin
        old = shadow_bank[a];
        if (a == vrf_pkg::ADR_KEY) begin
          if (!shadow_unlocked && b.write_data == vrf_pkg::KEY_SECOND
              && old == vrf_pkg::KEY_FIRST)
            shadow_unlocked = 1'b1;
          else if (shadow_unlocked)
            shadow_unlocked = 1'b0;
        end
        if (shadow_unlocked || a <= vrf_pkg::ADR_KEY) begin
          shadow_bank[a] = b.write_data;
          case (a)
            vrf_pkg::ADR_CMP_HI: shadow_compare[8] = b.write_data[7];
            vrf_pkg::ADR_CMP_LO: shadow_compare[7:0] = b.write_data;
            vrf_pkg::ADR_IRQ_STATUS: begin
              shadow_status = shadow_status & ~b.write_data & ~vrf_pkg::OR_NIBBLE
                              & shadow_bank[vrf_pkg::ADR_IRQ_ENABLE];
              settle_irq_line();
            end
            vrf_pkg::ADR_IRQ_ENABLE: shadow_bank[a] = b.write_data & ~vrf_pkg::OR_NIBBLE;
            vrf_pkg::ADR_MAP:
              r.memory_map_changed = |((b.write_data ^ old) & vrf_pkg::MAP_MASK);
            default: ;
          endcase
        end
      end
      vrf_pkg::CMD_READ: begin
        if (!shadow_unlocked && a > vrf_pkg::ADR_KEY) begin
          r.read_data = vrf_pkg::RD_UNMAPPED;
        end else begin
          case (a)
            vrf_pkg::ADR_CMP_HI:
              r.read_data = {b.current_line[8], shadow_bank[a][6:0]};
            vrf_pkg::ADR_CMP_LO:     r.read_data = b.current_line[7:0];
            vrf_pkg::ADR_CTRL2:      r.read_data = shadow_bank[a] | vrf_pkg::OR_CTRL2;
            vrf_pkg::ADR_MEMPTR:     r.read_data = shadow_bank[a] | vrf_pkg::OR_MEMPTR;
            vrf_pkg::ADR_IRQ_STATUS: r.read_data = shadow_status | vrf_pkg::OR_STATUS;
            vrf_pkg::ADR_IRQ_ENABLE: r.read_data = shadow_bank[a] | vrf_pkg::OR_NIBBLE;
            default: begin
              r.read_data = shadow_bank[a];
              if (a >= vrf_pkg::ADR_EXT_LO && a < vrf_pkg::ADR_KEY)
                r.read_data = r.read_data | vrf_pkg::OR_NIBBLE;
            end
          endcase
        end
      end
      vrf_pkg::CMD_TICK: begin
        // compare value 511 also fires on line 0
        shadow_status[0] = (b.current_line == shadow_compare)
                           || (shadow_compare == vrf_pkg::LINE_WRAP && b.current_line == '0);
        shadow_status = shadow_status & shadow_bank[vrf_pkg::ADR_IRQ_ENABLE];
        settle_irq_line();
      end
      default: ;
    endcase
    r.irq_active        = shadow_irq;
    r.slow_clock_select = shadow_bank[vrf_pkg::ADR_CLOCK][vrf_pkg::CLOCK_BIT];
    r.extended_mode     = shadow_unlocked;
    return r;
  endfunction

  function automatic int idle_pct(bit sink_side);
    if (beats_taken < total_beats / 3) return sink_side ? 68 : 13;
    if (beats_taken < 2 * total_beats / 3) return sink_side ? 13 : 68;
    return 0;
  endfunction

  task automatic add_beat(logic [1:0] cmd, logic [vrf_pkg::ADDR_BITS-1:0] addr,
                          logic [vrf_pkg::DATA_BITS-1:0] data,
                          logic [vrf_pkg::LINE_BITS-1:0] line, logic hold);
    queued_beat_t q;
    q.hold              = hold;
    q.beat.command      = cmd;
    q.beat.reg_address  = addr;
    q.beat.write_data   = data;
    q.beat.current_line = line;
    pending_beats.push_back(q);
    if (cmd == vrf_pkg::CMD_WRITE && addr[5:0] == vrf_pkg::ADR_CMP_HI[5:0])
      gen_compare[8] = data[7];
    if (cmd == vrf_pkg::CMD_WRITE && addr[5:0] == vrf_pkg::ADR_CMP_LO[5:0])
      gen_compare[7:0] = data;
  endtask

  function automatic logic [vrf_pkg::ADDR_BITS-1:0] pick_addr();
    if ($urandom_range(1)) return rand_addr();
    case ($urandom_range(13))
      0:  return vrf_pkg::ADR_CMP_HI;
      1:  return vrf_pkg::ADR_CMP_LO;
      2:  return vrf_pkg::ADR_CTRL2;
      3:  return vrf_pkg::ADR_MEMPTR;
      4:  return vrf_pkg::ADR_IRQ_STATUS;
      5:  return vrf_pkg::ADR_IRQ_ENABLE;
      6:  return vrf_pkg::ADR_EXT_LO;
      7:  return ADR_EXT_HI;
      8:  return vrf_pkg::ADR_KEY;
      9:  return vrf_pkg::ADR_MAP;
      10: return vrf_pkg::ADR_CLOCK;
      11: return ADR_LOCKED_TOP;
      12: return ADR_UPPER;
      default: return ADR_TOP;
    endcase
  endfunction

  function automatic logic [vrf_pkg::LINE_BITS-1:0] pick_line();
    case ($urandom_range(3))
      0:       return gen_compare;
      1:       return '0;
      default: return rand_line();
    endcase
  endfunction

  task automatic add_random_beat();
    int roll;
    roll = $urandom_range(99);
    if (roll < 35)
      add_beat(vrf_pkg::CMD_WRITE, pick_addr(), rand_data(), rand_line(), rand_hold());
    else if (roll < 70)
      add_beat(vrf_pkg::CMD_READ, pick_addr(), rand_data(), rand_line(), rand_hold());
    else if (roll < 95)
      add_beat(vrf_pkg::CMD_TICK, rand_addr(), rand_data(), pick_line(), 1'b0);
    else
      add_beat(CMD_NONE, pick_addr(), rand_data(), rand_line(), 1'b0);
  endtask

  // request side
  always @(posedge clk) begin
    if (rst) begin
      request.valid <= 1'b0;
    end else begin
      if (request.valid && request.ready) begin
        expected_responses.push_back(predict_response(request.data));
        beats_taken++;
      end
      if (!request.valid || request.ready) begin
        if (pending_beats.size() != 0
            && !(pending_beats[0].hold && expected_responses.size() != 0)
            && $urandom_range(99) >= idle_pct(1'b0)) begin
          next_beat = pending_beats.pop_front();
          request.valid <= 1'b1;
          request.data  <= next_beat.beat;
        end else begin
          request.valid <= 1'b0;
        end
      end
    end
  end

  // response side
  always @(posedge clk) begin
    if (rst) begin
      response.ready <= 1'b0;
    end else begin
      response.ready <= ($urandom_range(99) >= idle_pct(1'b1));
      if (response.valid && response.ready) begin
        if (expected_responses.size() == 0) begin
          failures++;
          if (failures <= 10) $display("response beat with nothing pending: %p", response.data);
        end else begin
          want = expected_responses.pop_front();
          if (response.data.read_data !== want.read_data
              || response.data.irq_active !== want.irq_active
              || response.data.memory_map_changed !== want.memory_map_changed
              || response.data.slow_clock_select !== want.slow_clock_select
              || response.data.extended_mode !== want.extended_mode) begin
            failures++;
            if (failures <= 10) begin
              $display("mismatch: expected rd=%h irq=%b map=%b slow=%b ext=%b",
                       want.read_data, want.irq_active, want.memory_map_changed,
                       want.slow_clock_select, want.extended_mode);
              $display("          got      rd=%h irq=%b map=%b slow=%b ext=%b",
                       response.data.read_data, response.data.irq_active,
                       response.data.memory_map_changed, response.data.slow_clock_select,
                       response.data.extended_mode);
            end
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (request.valid && request.ready) || (response.valid && response.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int i;
    int roll;
    request.valid   = 1'b0;
    request.data    = '0;
    response.ready  = 1'b0;
    for (i = 0; i < 128; i++) shadow_bank[i] = '0;
    shadow_unlocked = 1'b0;
    shadow_compare  = '0;
    shadow_status   = '0;
    shadow_irq      = 1'b0;
    gen_compare     = '0;
    beats_taken     = 0;
    failures        = 0;
    quiet_cycles    = 0;

    // reset values and read merging
    add_beat(vrf_pkg::CMD_READ, vrf_pkg::ADR_CMP_HI, 8'h00, 9'h1FF, 1'b0);
    add_beat(vrf_pkg::CMD_READ, vrf_pkg::ADR_CMP_LO, 8'hFF, 9'h0AA, 1'b0);
    add_beat(vrf_pkg::CMD_READ, vrf_pkg::ADR_CTRL2, 8'h00, 9'h000, 1'b0);
    add_beat(vrf_pkg::CMD_READ, vrf_pkg::ADR_MEMPTR, 8'h00, 9'h000, 1'b0);
    add_beat(vrf_pkg::CMD_READ, vrf_pkg::ADR_IRQ_STATUS, 8'h00, 9'h000, 1'b0);
    add_beat(vrf_pkg::CMD_READ, vrf_pkg::ADR_EXT_LO, 8'h00, 9'h000, 1'b0);
    // compare 511 wraps onto line 0
    add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_IRQ_ENABLE, 8'hFF, 9'h000, 1'b0);
    add_beat(vrf_pkg::CMD_READ, vrf_pkg::ADR_IRQ_ENABLE, 8'h00, 9'h000, 1'b0);
    add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_CMP_HI, 8'h80, 9'h000, 1'b0);
    add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_CMP_LO, 8'hFF, 9'h000, 1'b0);
    add_beat(vrf_pkg::CMD_TICK, ADR_TOP, 8'h00, 9'h000, 1'b0);
    add_beat(vrf_pkg::CMD_READ, vrf_pkg::ADR_IRQ_STATUS, 8'h00, 9'h100, 1'b0);
    add_beat(vrf_pkg::CMD_TICK, 7'h00, 8'h00, 9'h005, 1'b0);
    add_beat(vrf_pkg::CMD_TICK, 7'h00, 8'h00, 9'h1FF, 1'b0);
    add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_IRQ_STATUS, 8'h01, 9'h000, 1'b0);
    // locked: upper space ignored, unlock key out of order
    add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_CLOCK, 8'h40, 9'h000, 1'b0);
    add_beat(vrf_pkg::CMD_READ, ADR_LOCKED_TOP, 8'h00, 9'h000, 1'b0);
    add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_KEY, vrf_pkg::KEY_SECOND, 9'h000, 1'b0);
    add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_KEY, vrf_pkg::KEY_FIRST, 9'h000, 1'b0);
    add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_KEY, vrf_pkg::KEY_SECOND, 9'h000, 1'b0);
    // extended space
    add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_CLOCK, 8'h40, 9'h000, 1'b0);
    add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_MAP, 8'hF8, 9'h000, 1'b0);
    add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_MAP, 8'hFF, 9'h000, 1'b0);
    add_beat(vrf_pkg::CMD_WRITE, ADR_TOP, 8'h5A, 9'h000, 1'b0);
    add_beat(vrf_pkg::CMD_READ, ADR_TOP, 8'h00, 9'h000, 1'b0);
    add_beat(vrf_pkg::CMD_READ, ADR_EXT_HI, 8'h00, 9'h000, 1'b0);
    add_beat(CMD_NONE, ADR_TOP, 8'hFF, 9'h1FF, 1'b0);
    add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_KEY, 8'h00, 9'h000, 1'b0);
    add_beat(vrf_pkg::CMD_READ, vrf_pkg::ADR_MAP, 8'h00, 9'h000, 1'b1);

    total_beats = pending_beats.size() + RANDOM_BEATS;
    while (pending_beats.size() < total_beats) begin
      roll = $urandom_range(9);
      if (roll < 2) begin
        // unlock, work in the upper space, maybe lock again
        add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_KEY, vrf_pkg::KEY_FIRST, rand_line(), 1'b0);
        add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_KEY, vrf_pkg::KEY_SECOND, rand_line(), 1'b0);
        repeat ($urandom_range(2, 8)) add_random_beat();
        if ($urandom_range(1))
          add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_KEY, rand_data(), rand_line(), 1'b0);
      end else if (roll == 2) begin
        // broken key sequence
        add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_KEY, vrf_pkg::KEY_FIRST, rand_line(), 1'b0);
        if ($urandom_range(1))
          add_beat(vrf_pkg::CMD_WRITE, pick_addr(), vrf_pkg::KEY_SECOND, rand_line(), 1'b0);
        else
          add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_KEY, rand_data(), rand_line(), 1'b0);
        add_random_beat();
      end else if (roll == 3) begin
        // raster compare setup and ticks
        add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_IRQ_ENABLE, rand_data() | 8'h01,
                 rand_line(), 1'b0);
        if ($urandom_range(7) == 0) begin
          add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_CMP_HI, rand_data() | 8'h80,
                   rand_line(), 1'b0);
          add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_CMP_LO, 8'hFF, rand_line(), 1'b0);
        end else begin
          add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_CMP_HI, rand_data(), rand_line(), 1'b0);
          add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_CMP_LO, rand_data(), rand_line(), 1'b0);
        end
        repeat ($urandom_range(2, 6)) begin
          add_beat(vrf_pkg::CMD_TICK, rand_addr(), rand_data(), pick_line(), 1'b0);
          if ($urandom_range(1))
            add_beat(vrf_pkg::CMD_READ, vrf_pkg::ADR_IRQ_STATUS, rand_data(), rand_line(),
                     1'b0);
        end
        if ($urandom_range(1))
          add_beat(vrf_pkg::CMD_WRITE, vrf_pkg::ADR_IRQ_STATUS, rand_data(), rand_line(),
                   1'b0);
      end else begin
        add_random_beat();
      end
    end
    total_beats = pending_beats.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0 || request.valid || expected_responses.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
